// File: rtl/core/hsvrgb_pkg.sv
// Shared types, constants and helper functions for the HSV to RGB converter.
package hsvrgb_pkg;

    localparam int HUE_PERIOD  = 360;
    localparam int SECTOR_DEG  = 60;
    localparam int FULL_SCALE  = 255;
    localparam int RAMP_PERIOD = 510;
    // Reciprocal of the hue period scaled by 2**HUE_RECIP_SHIFT, rounded down.
    localparam int HUE_RECIP_SHIFT = 24;
    localparam int HUE_RECIP       = (1 << HUE_RECIP_SHIFT) / HUE_PERIOD;

    typedef struct packed {
        logic [15:0] hue;
        logic [7:0]  saturation;
        logic [7:0]  brightness;
    } t_hsv;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } t_rgb;

    typedef enum logic [2:0] {
        SEC_0 = 3'd0,
        SEC_1 = 3'd1,
        SEC_2 = 3'd2,
        SEC_3 = 3'd3,
        SEC_4 = 3'd4,
        SEC_5 = 3'd5
    } t_sector;

    typedef struct packed {
        logic [8:0] hue;
        logic [7:0] chroma;
        logic [7:0] brightness;
    } t_hcv;

    typedef struct packed {
        logic [15:0] x_prod;
        logic [7:0]  chroma;
        logic [7:0]  brightness;
        t_sector     sector;
    } t_xcv;

    // Exact floor(p / 255) for any product of two 8-bit values.
    function automatic logic [7:0] div255(input logic [15:0] p);
        logic [16:0] sum;
        sum = 17'(p) + 17'(p[15:8]) + 17'd1;
        return sum[15:8];
    endfunction

endpackage

// File: rtl/core/hsvrgb_prep.sv
// Hue reduction modulo 360 and chroma calculation, two register stages.
module hsvrgb_prep import hsvrgb_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    output logic  o_ready,
    input  t_hsv  i_hsv,
    output logic  o_valid,
    input  logic  i_ready,
    output t_hcv  o_hcv
);

    logic        r_vld1;
    logic        r_vld2;
    logic        n_en1;
    logic        n_en2;
    logic [7:0]  r_quot;
    logic [15:0] r_hue;
    logic [15:0] r_sv;
    logic [7:0]  r_bright1;
    t_hcv        r_hcv;

    logic [31:0] n_prod;
    logic [16:0] n_qm;
    logic [16:0] n_rem;
    t_hcv        n_hcv;

    assign n_en2   = !r_vld2 || i_ready;
    assign n_en1   = !r_vld1 || n_en2;
    assign o_ready = n_en1;
    assign o_valid = r_vld2;
    assign o_hcv   = r_hcv;

    always_comb begin
        n_prod = 32'(i_hsv.hue) * 32'(HUE_RECIP);
        n_qm   = 17'(r_quot) * 17'(HUE_PERIOD);
        n_rem  = 17'(r_hue) - n_qm;
        if (n_rem >= 17'(HUE_PERIOD)) begin
            n_hcv.hue = 9'(n_rem - 17'(HUE_PERIOD));
        end else begin
            n_hcv.hue = 9'(n_rem);
        end
        n_hcv.chroma     = div255(r_sv);
        n_hcv.brightness = r_bright1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld1 <= 1'b0;
            r_vld2 <= 1'b0;
        end else begin
            if (n_en1) begin
                r_vld1 <= i_valid;
            end
            if (n_en2) begin
                r_vld2 <= r_vld1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (n_en1) begin
            r_quot    <= n_prod[HUE_RECIP_SHIFT +: 8];
            r_hue     <= i_hsv.hue;
            r_sv      <= 16'(i_hsv.saturation) * 16'(i_hsv.brightness);
            r_bright1 <= i_hsv.brightness;
        end
        if (n_en2) begin
            r_hcv <= n_hcv;
        end
    end

endmodule

// File: rtl/core/hsvrgb_ramp.sv
// Ramp, sector selection and secondary product, two register stages.
module hsvrgb_ramp import hsvrgb_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    output logic  o_ready,
    input  t_hcv  i_hcv,
    output logic  o_valid,
    input  logic  i_ready,
    output t_xcv  o_xcv
);

    logic       r_vld3;
    logic       r_vld4;
    logic       n_en3;
    logic       n_en4;
    logic [7:0] r_weight;
    logic [7:0] r_chroma;
    logic [7:0] r_bright;
    t_sector    r_sector;
    t_xcv       r_xcv;

    logic [13:0] n_h17;
    logic [10:0] n_raw;
    logic [8:0]  n_ramp;
    logic [7:0]  n_dist;
    t_sector     n_sector;

    assign n_en4   = !r_vld4 || i_ready;
    assign n_en3   = !r_vld3 || n_en4;
    assign o_ready = n_en3;
    assign o_valid = r_vld4;
    assign o_xcv   = r_xcv;

    always_comb begin
        // 255 / 60 is exactly 17 / 4.
        n_h17 = 14'({i_hcv.hue, 4'b0000}) + 14'(i_hcv.hue);
        n_raw = n_h17[12:2];
        priority if (n_raw >= 11'(2 * RAMP_PERIOD)) begin
            n_ramp = 9'(n_raw - 11'(2 * RAMP_PERIOD));
        end else if (n_raw >= 11'(RAMP_PERIOD)) begin
            n_ramp = 9'(n_raw - 11'(RAMP_PERIOD));
        end else begin
            n_ramp = 9'(n_raw);
        end
        if (n_ramp >= 9'(FULL_SCALE)) begin
            n_dist = 8'(n_ramp - 9'(FULL_SCALE));
        end else begin
            n_dist = 8'(9'(FULL_SCALE) - n_ramp);
        end
        priority if (i_hcv.hue < 9'(SECTOR_DEG)) begin
            n_sector = SEC_0;
        end else if (i_hcv.hue < 9'(2 * SECTOR_DEG)) begin
            n_sector = SEC_1;
        end else if (i_hcv.hue < 9'(3 * SECTOR_DEG)) begin
            n_sector = SEC_2;
        end else if (i_hcv.hue < 9'(4 * SECTOR_DEG)) begin
            n_sector = SEC_3;
        end else if (i_hcv.hue < 9'(5 * SECTOR_DEG)) begin
            n_sector = SEC_4;
        end else begin
            n_sector = SEC_5;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld3 <= 1'b0;
            r_vld4 <= 1'b0;
        end else begin
            if (n_en3) begin
                r_vld3 <= i_valid;
            end
            if (n_en4) begin
                r_vld4 <= r_vld3;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (n_en3) begin
            r_weight <= 8'(FULL_SCALE) - n_dist;
            r_chroma <= i_hcv.chroma;
            r_bright <= i_hcv.brightness;
            r_sector <= n_sector;
        end
        if (n_en4) begin
            r_xcv.x_prod     <= 16'(r_chroma) * 16'(r_weight);
            r_xcv.chroma     <= r_chroma;
            r_xcv.brightness <= r_bright;
            r_xcv.sector     <= r_sector;
        end
    end

endmodule

// File: rtl/core/hsvrgb_mix.sv
// Component placement by sector and offset addition, registered output stage.
module hsvrgb_mix import hsvrgb_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    output logic  o_ready,
    input  t_xcv  i_xcv,
    output logic  o_valid,
    input  logic  i_ready,
    output t_rgb  o_rgb
);

    logic       r_vld5;
    logic       n_en5;
    t_rgb       r_rgb;
    t_rgb       n_rgb;
    logic [7:0] n_x;
    logic [7:0] n_c;
    logic [7:0] n_m;

    assign n_en5   = !r_vld5 || i_ready;
    assign o_ready = n_en5;
    assign o_valid = r_vld5;
    assign o_rgb   = r_rgb;

    always_comb begin
        n_x = div255(i_xcv.x_prod);
        n_c = i_xcv.chroma;
        n_m = i_xcv.brightness - i_xcv.chroma;
        unique case (i_xcv.sector)
            SEC_0: begin
                n_rgb = '{red: n_c, green: n_x, blue: 8'd0};
            end
            SEC_1: begin
                n_rgb = '{red: n_x, green: n_c, blue: 8'd0};
            end
            SEC_2: begin
                n_rgb = '{red: 8'd0, green: n_c, blue: n_x};
            end
            SEC_3: begin
                n_rgb = '{red: 8'd0, green: n_x, blue: n_c};
            end
            SEC_4: begin
                n_rgb = '{red: n_x, green: 8'd0, blue: n_c};
            end
            default: begin
                n_rgb = '{red: n_c, green: 8'd0, blue: n_x};
            end
        endcase
        n_rgb.red   = n_rgb.red + n_m;
        n_rgb.green = n_rgb.green + n_m;
        n_rgb.blue  = n_rgb.blue + n_m;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld5 <= 1'b0;
        end else if (n_en5) begin
            r_vld5 <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (n_en5) begin
            r_rgb <= n_rgb;
        end
    end

endmodule

// File: rtl/core/hsv_to_rgb_converter_unit.sv
// Top level of the five-stage HSV to RGB converter pipeline.
//
//   Channel   Valid     Ready     Beat
//   input     i_valid   o_ready   i_hsv (hue, saturation, brightness)
//   output    o_valid   i_ready   o_rgb (red, green, blue)
//
// One beat is taken per cycle unless a stalled output has filled every stage.
// The pipeline depth is set by the two multiplier stages and the two divisions by 255.
// Every stage holds its own valid bit, so an empty stage fills even while the output stalls.
// Synchronous reset clears the valid bits only; payload registers keep their contents.
module hsv_to_rgb_converter_unit import hsvrgb_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_ready,
    input  t_hsv i_hsv,
    output logic o_valid,
    input  logic i_ready,
    output t_rgb o_rgb
);

    logic prep_valid;
    logic ramp_ready;
    t_hcv prep_hcv;
    logic ramp_valid;
    logic mix_ready;
    t_xcv ramp_xcv;

    hsvrgb_prep u_prep (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_hsv   (i_hsv),
        .o_valid (prep_valid),
        .i_ready (ramp_ready),
        .o_hcv   (prep_hcv)
    );

    hsvrgb_ramp u_ramp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (prep_valid),
        .o_ready (ramp_ready),
        .i_hcv   (prep_hcv),
        .o_valid (ramp_valid),
        .i_ready (mix_ready),
        .o_xcv   (ramp_xcv)
    );

    hsvrgb_mix u_mix (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (ramp_valid),
        .o_ready (mix_ready),
        .i_xcv   (ramp_xcv),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_rgb   (o_rgb)
    );

`ifndef SYNTHESIS
    a_chroma_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        prep_valid |-> (prep_hcv.chroma <= prep_hcv.brightness))
        else $error("chroma exceeds brightness");

    a_hue_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        prep_valid |-> (prep_hcv.hue < 9'(HUE_PERIOD)))
        else $error("reduced hue out of range");

    a_xprod_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ramp_valid |-> (ramp_xcv.x_prod <= 16'(ramp_xcv.chroma) * 16'(FULL_SCALE)))
        else $error("secondary product exceeds chroma");

    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_ready |-> (o_valid && !i_ready && ramp_valid && prep_valid))
        else $error("input stalled with a free stage");
`endif

endmodule

// File: bench/tb.sv
// Testbench for the HSV to RGB converter: directed and random pixels checked against a predictor.
`timescale 1ns / 1ps

module tb;
    import hsvrgb_pkg::*;

    localparam int CYCLE_LIMIT = 200000;

    class rgb_scoreboard;
        t_rgb        expected_q[$];
        int unsigned error_count;

        function new();
            error_count = 0;
        endfunction

        function t_rgb convert_pixel(t_hsv px);
            int unsigned hue_deg, sat, val, chroma, ramp, ramp_dev, second, base, r, g, b;
            t_rgb        rgb;
            hue_deg  = px.hue % HUE_PERIOD;
            sat      = px.saturation;
            val      = px.brightness;
            chroma   = (val * sat) / FULL_SCALE;
            ramp     = ((hue_deg * FULL_SCALE) / SECTOR_DEG) % RAMP_PERIOD;
            ramp_dev = (ramp >= FULL_SCALE) ? ramp - FULL_SCALE : FULL_SCALE - ramp;
            second   = (chroma * (FULL_SCALE - ramp_dev)) / FULL_SCALE;
            base     = val - chroma;
            case (t_sector'(hue_deg / SECTOR_DEG))
                SEC_0: begin r = chroma; g = second; b = 0;      end
                SEC_1: begin r = second; g = chroma; b = 0;      end
                SEC_2: begin r = 0;      g = chroma; b = second; end
                SEC_3: begin r = 0;      g = second; b = chroma; end
                SEC_4: begin r = second; g = 0;      b = chroma; end
                default: begin r = chroma; g = 0;    b = second; end
            endcase
            rgb.red   = 8'(r + base);
            rgb.green = 8'(g + base);
            rgb.blue  = 8'(b + base);
            return rgb;
        endfunction

        function void note_input(t_hsv px);
            expected_q.push_back(convert_pixel(px));
        endfunction

        function void check_result(t_rgb got);
            t_rgb want;
            if (expected_q.size() == 0) begin
                $display("%0t: result %h arrived with none expected", $time, got);
                error_count++;
                return;
            end
            want = expected_q.pop_front();
            if (got.red !== want.red) begin
                $display("%0t: red expected %0d, got %0d", $time, want.red, got.red);
                error_count++;
            end
            if (got.green !== want.green) begin
                $display("%0t: green expected %0d, got %0d", $time, want.green, got.green);
                error_count++;
            end
            if (got.blue !== want.blue) begin
                $display("%0t: blue expected %0d, got %0d", $time, want.blue, got.blue);
                error_count++;
            end
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n = 1'b0;
    logic i_valid = 1'b0;
    logic o_ready;
    t_hsv i_hsv   = '0;
    logic o_valid;
    logic i_ready = 1'b0;
    t_rgb o_rgb;

    rgb_scoreboard board = new();
    int tx_idle_pct  = 0;
    int rx_stall_pct = 0;
    int hold_left    = 0;
    bit hold_req     = 1'b0;
    int cycle_count  = 0;

    hsv_to_rgb_converter_unit u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_hsv   (i_hsv),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_rgb   (o_rgb)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("DONE: errors detected");
        $finish;
    end

    // A long hold-off lets the pipeline fill while the sender keeps offering pixels.
    always @(negedge i_clk) begin
        if (hold_req) begin
            hold_left = 80;
            hold_req  = 1'b0;
        end
        if (hold_left > 0) begin
            i_ready = 1'b0;
            hold_left--;
        end else begin
            i_ready = ($urandom_range(99) >= rx_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid === 1'b1 && i_ready) begin
            board.check_result(o_rgb);
        end
    end

    task automatic send_pixel(input t_hsv px);
        while ($urandom_range(99) < tx_idle_pct) begin
            i_valid = 1'b0;
            @(negedge i_clk);
        end
        i_valid = 1'b1;
        i_hsv   = px;
        @(posedge i_clk);
        while (o_ready !== 1'b1) @(posedge i_clk);
        board.note_input(px);
        @(negedge i_clk);
        i_valid = 1'b0;
    endtask

    function automatic logic [7:0] random_level();
        case ($urandom_range(9))
            0: return 8'd0;
            1: return 8'd255;
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    function automatic t_hsv random_pixel();
        t_hsv px;
        px.hue        = ($urandom_range(1)) ? 16'($urandom_range(359)) : 16'($urandom);
        px.saturation = random_level();
        px.brightness = random_level();
        return px;
    endfunction

    task automatic send_random(input int count);
        repeat (count) send_pixel(random_pixel());
    endtask

    task automatic wait_drained();
        while (board.expected_q.size() != 0) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    initial begin
        t_hsv  px;
        int    k;
        int    hues[16];
        hues = '{0, 30, 59, 60, 90, 119, 120, 179, 180, 239, 240, 299, 300, 359,
                 360, 65535};
        repeat (4) @(negedge i_clk);
        i_rst_n = 1'b1;

        for (k = 0; k < 16; k++) begin
            px.hue        = 16'(hues[k]);
            px.saturation = 8'd255;
            px.brightness = 8'd255;
            send_pixel(px);
        end
        px = '{hue: 16'd200, saturation: 8'd0,   brightness: 8'd255}; send_pixel(px);
        px = '{hue: 16'd200, saturation: 8'd255, brightness: 8'd0};   send_pixel(px);
        px = '{hue: 16'd0,   saturation: 8'd0,   brightness: 8'd0};   send_pixel(px);
        px = '{hue: 16'd719, saturation: 8'd128, brightness: 8'd200}; send_pixel(px);
        px = '{hue: 16'd45,  saturation: 8'd1,   brightness: 8'd254}; send_pixel(px);
        px = '{hue: 16'd330, saturation: 8'd170, brightness: 8'd85};  send_pixel(px);
        wait_drained();

        hold_req = 1'b1;
        send_random(160);
        wait_drained();

        tx_idle_pct = 83;
        send_random(150);
        wait_drained();

        tx_idle_pct  = 0;
        rx_stall_pct = 83;
        send_random(150);
        wait_drained();

        tx_idle_pct  = 17;
        rx_stall_pct = 17;
        send_random(165);
        i_valid = 1'b0;

        while (board.expected_q.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (board.error_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
